// File: hw/rtl/grbk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package grbk_pkg;

   localparam int GROUP_W = 17;
   localparam int ORDER_W = 30;
   localparam int RANK_W  = 7;
   localparam int INDEX_W = 6;

   typedef struct packed {
      logic               valid;
      logic [GROUP_W-1:0] group;
      logic [ORDER_W-1:0] order;
      logic [RANK_W-1:0]  rank;
   } token_type;

   typedef struct packed {
      logic               occ;
      logic [GROUP_W-1:0] group;
      logic [ORDER_W-1:0] order;
      logic [RANK_W-1:0]  rank;
   } cell_type;

endpackage
`default_nettype wire

// File: hw/rtl/grouped_rank_by_key.sv
`timescale 1ns / 1ps
`default_nettype none
// Ranks items within their group by ascending order key, ties by arrival.
// Items enter one per cycle into a chain of MAX_ITEMS cells; each item walks
// the chain one cell per cycle, comparing against every stored item, and
// settles in the first empty cell. Items past capacity are dropped and set
// the overflow flag. After the transfer marked tlast, no input is taken until
// the run is out: the walking items drain through the chain, then one result per
// cycle shifts out of cell 0 in arrival order while rsp_tready is high.
module grouped_rank_by_key
   import grbk_pkg::*;
#(
   parameter int MAX_ITEMS = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // group_key[16:0], order_key[46:17], zero pad
   input  wire logic        req_tlast,   // last_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // item_index[5:0], group_out[22:6],
                                         // rank_in_group[29:23], overflow[30], zero pad
   output logic             rsp_tlast    // last_result
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   typedef enum logic [1:0] {LOAD, DRAIN, SEND} state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   left_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic               dropped_ff;

   token_type tok   [MAX_ITEMS+1];
   cell_type  cells [MAX_ITEMS+1];
   logic      busy  [MAX_ITEMS+1];

   logic req_xfer, rsp_xfer, room, shift;

   assign req_tready = (state_ff == LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign room       = count_ff < CNT_W'(MAX_ITEMS);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign shift      = rsp_xfer;

   always_comb begin
      tok[0].valid = req_xfer && room;
      tok[0].group = req_tdata[GROUP_W-1:0];
      tok[0].order = req_tdata[GROUP_W+ORDER_W-1:GROUP_W];
      tok[0].rank  = RANK_W'(1);
      cells[MAX_ITEMS] = '0;
   end

   for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
      grbk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok[j]),
         .tok_out   (tok[j+1]),
         .shift     (shift),
         .next_cell (cells[j+1]),
         .cell_out  (cells[j])
      );
   end

   always_comb begin
      busy[0] = 1'b0;
      for (int j = 0; j < MAX_ITEMS; j++) begin
         busy[j+1] = busy[j] | tok[j+1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LOAD;
         count_ff   <= '0;
         left_ff    <= '0;
         idx_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            LOAD: begin
               if (req_xfer) begin
                  if (room) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else begin
                     dropped_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     left_ff  <= room ? count_ff + CNT_W'(1) : count_ff;
                     state_ff <= DRAIN;
                  end
               end
            end
            DRAIN: begin
               if (!busy[MAX_ITEMS]) begin
                  state_ff <= SEND;
               end
            end
            SEND: begin
               if (rsp_xfer) begin
                  idx_ff  <= idx_ff + INDEX_W'(1);
                  left_ff <= left_ff - CNT_W'(1);
                  if (left_ff == CNT_W'(1)) begin
                     state_ff   <= LOAD;
                     count_ff   <= '0;
                     idx_ff     <= '0;
                     dropped_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == SEND);
   assign rsp_tlast  = (left_ff == CNT_W'(1));
   assign rsp_tdata  = {1'b0, dropped_ff, cells[0].rank, cells[0].group, idx_ff};

endmodule
`default_nettype wire

// File: hw/rtl/grbk_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module grbk_cell
   import grbk_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type tok_in,
   output token_type      tok_out,
   input  wire logic      shift,
   input  wire cell_type  next_cell,
   output cell_type       cell_out
);

   cell_type  cell_ff,  cell_in;
   token_type tok_ff,   tok_in_nxt;
   logic      hit, le, store;

   always_comb begin
      hit   = tok_in.valid && cell_ff.occ && (cell_ff.group == tok_in.group);
      le    = cell_ff.order <= tok_in.order;
      store = tok_in.valid && !cell_ff.occ;

      cell_in = cell_ff;
      if (shift) begin
         cell_in = next_cell;
      end else if (store) begin
         cell_in.occ   = 1'b1;
         cell_in.group = tok_in.group;
         cell_in.order = tok_in.order;
         cell_in.rank  = tok_in.rank;
      end else if (hit && !le) begin
         cell_in.rank = cell_ff.rank + RANK_W'(1);
      end

      tok_in_nxt       = tok_in;
      tok_in_nxt.valid = tok_in.valid && cell_ff.occ;
      if (hit && le) begin
         tok_in_nxt.rank = tok_in.rank + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.occ  <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         cell_ff.occ  <= cell_in.occ;
         tok_ff.valid <= tok_in_nxt.valid;
      end
      cell_ff.group <= cell_in.group;
      cell_ff.order <= cell_in.order;
      cell_ff.rank  <= cell_in.rank;
      tok_ff.group  <= tok_in_nxt.group;
      tok_ff.order  <= tok_in_nxt.order;
      tok_ff.rank   <= tok_in_nxt.rank;
   end

   assign tok_out  = tok_ff;
   assign cell_out = cell_ff;

endmodule
`default_nettype wire
